// ===== hdl/fmacl_pkg.sv =====
// Shared types and constants for the first-match IPv4 access list filter.
// Used by fmacl_rule_ram, fmacl_scan and first_match_ip_access_filter.
package fmacl_pkg;

    localparam int RULE_ENTRIES = 16;
    localparam int IDX_W        = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
    localparam int CNT_W        = $clog2(RULE_ENTRIES + 1);

    localparam logic [1:0] CFG_ENABLED = 2'd0;
    localparam logic [1:0] CFG_DEFAULT = 2'd1;
    localparam logic [1:0] CFG_COUNT   = 2'd2;

    localparam logic OP_CHECK = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] mask;
        logic        permit;
    } t_rule;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_rule            rule;
    } t_ram_wr;

    typedef struct packed {
        logic       enabled;
        logic       dflt;
        logic [4:0] count;
    } t_cfg;

    typedef struct packed {
        logic       done;
        logic       was_write;
        logic       permitted;
        logic       matched;
        logic [3:0] match_index;
    } t_result;

endpackage

// ===== hdl/first_match_ip_access_filter.sv =====
// First-match IPv4 access list: a rule write needs no scan, its result shows the next cycle.
// A check that scans entries reads one rule per cycle from the table's single read port:
// it stays busy until a rule matches or the last entry in use is read, and the result is
// registered after that decision; disabled list, zero address or empty list skip the scan.
// A new request is taken in the cycle a result shows; the receiver cannot stall.
// Reset clears the configuration registers and control; the rule table stays unwritten.
module first_match_ip_access_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_operation,
    input  logic [3:0]  i_rule_index,
    input  logic [31:0] i_rule_address,
    input  logic [31:0] i_rule_mask,
    input  logic        i_rule_permit,
    input  logic [31:0] i_ip_address,
    output logic        o_done,
    output logic        o_was_write,
    output logic        o_permitted,
    output logic        o_matched,
    output logic [3:0]  o_match_index,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    fmacl_pkg::t_cfg    r_cfg;
    fmacl_pkg::t_ram_wr wr;
    fmacl_pkg::t_rule   rd_rule;
    fmacl_pkg::t_result res;
    logic [fmacl_pkg::IDX_W-1:0] rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fmacl_pkg::CFG_ENABLED: r_cfg.enabled <= i_cfg_data[0];
                fmacl_pkg::CFG_DEFAULT: r_cfg.dflt    <= i_cfg_data[0];
                fmacl_pkg::CFG_COUNT:   r_cfg.count   <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    fmacl_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_operation    (i_operation),
        .i_rule_index   (i_rule_index),
        .i_rule_address (i_rule_address),
        .i_rule_mask    (i_rule_mask),
        .i_rule_permit  (i_rule_permit),
        .i_ip_address   (i_ip_address),
        .i_cfg          (r_cfg),
        .i_rd_rule      (rd_rule),
        .o_busy         (o_busy),
        .o_wr           (wr),
        .o_rd_addr      (rd_addr),
        .o_res          (res)
    );

    fmacl_rule_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_rule (rd_rule)
    );

    assign o_done        = res.done;
    assign o_was_write   = res.was_write;
    assign o_permitted   = res.permitted;
    assign o_matched     = res.matched;
    assign o_match_index = res.match_index;

endmodule

// ===== hdl/fmacl_rule_ram.sv =====
// Rule table: one write port, one registered read port.
// Depends on fmacl_pkg for the rule and write-port types.
module fmacl_rule_ram (
    input  logic                       i_clk,
    input  fmacl_pkg::t_ram_wr         i_wr,
    input  logic [fmacl_pkg::IDX_W-1:0] i_rd_addr,
    output fmacl_pkg::t_rule           o_rd_rule
);

    fmacl_pkg::t_rule r_mem [fmacl_pkg::RULE_ENTRIES];
    fmacl_pkg::t_rule r_rd_rule;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.rule;
        end
        r_rd_rule <= r_mem[i_rd_addr];
    end

    assign o_rd_rule = r_rd_rule;

endmodule

// ===== hdl/fmacl_scan.sv =====
// Request control: rule writes, and the first-match scan over the rule table.
// Depends on fmacl_pkg; drives the ports of fmacl_rule_ram.
module fmacl_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_operation,
    input  logic [3:0]                  i_rule_index,
    input  logic [31:0]                 i_rule_address,
    input  logic [31:0]                 i_rule_mask,
    input  logic                        i_rule_permit,
    input  logic [31:0]                 i_ip_address,
    input  fmacl_pkg::t_cfg             i_cfg,
    input  fmacl_pkg::t_rule            i_rd_rule,
    output logic                        o_busy,
    output fmacl_pkg::t_ram_wr          o_wr,
    output logic [fmacl_pkg::IDX_W-1:0] o_rd_addr,
    output fmacl_pkg::t_result          o_res
);

    localparam int IDX_W = fmacl_pkg::IDX_W;
    localparam int CNT_W = fmacl_pkg::CNT_W;

    fmacl_pkg::t_state  r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_limit, n_limit;
    logic [31:0]        r_ip, n_ip;
    fmacl_pkg::t_result r_res, n_res;

    logic               accept;
    logic               is_write;
    logic               quick;
    logic               hit;
    logic               last;
    logic [CNT_W-1:0]   limit;
    logic [CNT_W-1:0]   idx_next;

    always_comb begin
        if (32'(i_cfg.count) > 32'(fmacl_pkg::RULE_ENTRIES)) begin
            limit = CNT_W'(fmacl_pkg::RULE_ENTRIES);
        end else begin
            limit = CNT_W'(i_cfg.count);
        end
    end

    assign accept   = i_start && (r_state == fmacl_pkg::S_IDLE);
    assign is_write = (i_operation == fmacl_pkg::OP_WRITE);
    assign quick    = !i_cfg.enabled || (i_ip_address == 32'd0) || (limit == '0);
    assign hit      = ((r_ip & i_rd_rule.mask) == i_rd_rule.addr);
    assign idx_next = CNT_W'(r_idx) + CNT_W'(1);
    assign last     = (idx_next == r_limit);

    always_comb begin
        n_state = r_state;
        case (r_state)
            fmacl_pkg::S_IDLE: begin
                if (accept && !is_write && !quick) begin
                    n_state = fmacl_pkg::S_SCAN;
                end
            end
            fmacl_pkg::S_SCAN: begin
                if (hit || last) begin
                    n_state = fmacl_pkg::S_IDLE;
                end
            end
            default: n_state = fmacl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_idx          = r_idx;
        n_limit        = r_limit;
        n_ip           = r_ip;
        n_res          = '0;
        o_wr.en        = 1'b0;
        o_wr.addr      = IDX_W'(i_rule_index);
        o_wr.rule.addr = i_rule_address;
        o_wr.rule.mask = i_rule_mask;
        o_wr.rule.permit = i_rule_permit;
        o_rd_addr      = '0;
        case (r_state)
            fmacl_pkg::S_IDLE: begin
                if (accept) begin
                    if (is_write) begin
                        o_wr.en         = (32'(i_rule_index) < 32'(fmacl_pkg::RULE_ENTRIES));
                        n_res.done      = 1'b1;
                        n_res.was_write = 1'b1;
                    end else if (quick) begin
                        n_res.done      = 1'b1;
                        n_res.permitted = i_cfg.enabled & i_cfg.dflt;
                    end else begin
                        n_ip    = i_ip_address;
                        n_limit = limit;
                        n_idx   = '0;
                    end
                end
            end
            fmacl_pkg::S_SCAN: begin
                o_rd_addr = r_idx + IDX_W'(1);
                if (hit) begin
                    n_res.done        = 1'b1;
                    n_res.permitted   = i_rd_rule.permit;
                    n_res.matched     = 1'b1;
                    n_res.match_index = 4'(r_idx);
                end else if (last) begin
                    n_res.done      = 1'b1;
                    n_res.permitted = i_cfg.dflt;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fmacl_pkg::S_IDLE;
            r_res.done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_res.done <= n_res.done;
        end
        r_idx             <= n_idx;
        r_limit           <= n_limit;
        r_ip              <= n_ip;
        r_res.was_write   <= n_res.was_write;
        r_res.permitted   <= n_res.permitted;
        r_res.matched     <= n_res.matched;
        r_res.match_index <= n_res.match_index;
    end

    assign o_busy = (r_state == fmacl_pkg::S_SCAN);
    assign o_res  = r_res;

endmodule
